>>> hw/rtl/im2col_pkg.sv
// ----------------------------------------------------------------------------
// im2col_pkg
// Shared sizes, register indexes, controller commands and clamp helpers.
// ----------------------------------------------------------------------------
package im2col_pkg;

  localparam int MAX_HEIGHT   = 32;
  localparam int MAX_WIDTH    = 32;
  localparam int MAX_CHANNELS = 4;
  localparam int KERNEL_MAX   = 32;
  localparam int WORD_BITS    = 32;
  localparam int STORE_DEPTH  = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
  localparam int ADDR_W       = $clog2(STORE_DEPTH);
  localparam int IDX_W        = 12;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_HEIGHT  = 3'd0,
    REG_IMAGE_WIDTH   = 3'd1,
    REG_CHANNEL_COUNT = 3'd2,
    REG_KERNEL_HEIGHT = 3'd3,
    REG_KERNEL_WIDTH  = 3'd4,
    REG_PAD_AMOUNT    = 3'd5,
    REG_STEP_SIZE     = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic idle;
    logic load_en;
    logic read_en;
    logic addr_en;
    logic fetch_en;
  } dp_cmd_t;

  function automatic logic [5:0] clamp6(input logic [5:0] v, input logic [5:0] hi);
    logic [5:0] r;
    r = v;
    if (v == 6'd0) begin
      r = 6'd1;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

  function automatic logic [2:0] clamp3(input logic [2:0] v, input logic [2:0] hi);
    logic [2:0] r;
    r = v;
    if (v == 3'd0) begin
      r = 3'd1;
    end else if (v > hi) begin
      r = hi;
    end
    return r;
  endfunction

endpackage

>>> hw/rtl/im2col_ctrl.sv
// ----------------------------------------------------------------------------
// im2col_ctrl
// Sequencer: takes commands, steps a read through address, fetch and emit.
// ----------------------------------------------------------------------------
module im2col_ctrl import im2col_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  logic    in_mode,
  output logic    busy,
  output logic    out_strobe,
  output dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_ADDR  = 4'b0010,
    ST_FETCH = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    out_strobe   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.idle    = 1'b1;
        cmd.load_en = start && !in_mode;
        cmd.read_en = start && in_mode;
        if (start && in_mode) begin
          state_nxt = ST_ADDR;
        end
      end
      ST_ADDR: begin
        cmd.addr_en = 1'b1;
        state_nxt   = ST_FETCH;
      end
      ST_FETCH: begin
        cmd.fetch_en = 1'b1;
        state_nxt    = ST_EMIT;
      end
      ST_EMIT: begin
        out_strobe = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = !cmd.idle;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hw/rtl/im2col_dp.sv
// ----------------------------------------------------------------------------
// im2col_dp
// Datapath: config registers, image store, load and window counters,
// address arithmetic and result registers.
// ----------------------------------------------------------------------------
module im2col_dp import im2col_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  input  logic [WORD_BITS-1:0]  in_pixel_word,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic [WORD_BITS-1:0]  out_element_word,
  output logic [IDX_W-1:0]      out_matrix_row,
  output logic [IDX_W-1:0]      out_matrix_column,
  output logic                  out_row_end,
  output logic                  out_matrix_end,
  output logic                  out_status
);

  localparam logic [5:0] MAX_H6  = 6'(MAX_HEIGHT);
  localparam logic [5:0] MAX_W6  = 6'(MAX_WIDTH);
  localparam logic [5:0] MAX_K6  = 6'(KERNEL_MAX);
  localparam logic [2:0] MAX_CH3 = 3'(MAX_CHANNELS);

  logic [5:0] height_r, width_r, kern_h_r, kern_w_r, step_r;
  logic [2:0] chans_r, pad_r;

  logic [5:0] h_c, w_c, kh_c, kw_c, s_c;
  logic [2:0] ch_c;
  logic [6:0] ph, pw;
  logic       geom_err;
  logic       cfg_we;
  logic       cfg_hit;

  logic [ADDR_W-1:0] ld_pos_r, ld_pos_nxt;
  logic [4:0]        ld_col_r, ld_col_nxt, ld_row_r, ld_row_nxt;
  logic [1:0]        ld_chan_r, ld_chan_nxt;
  logic              ldc_last, ldr_last, ldch_last;

  logic [5:0]       row_base_r, row_base_nxt, col_base_r, col_base_nxt;
  logic [1:0]       chan_r, chan_nxt;
  logic [4:0]       win_row_r, win_row_nxt, win_col_r, win_col_nxt;
  logic [IDX_W-1:0] row_idx_r, row_idx_nxt, col_idx_r, col_idx_nxt;
  logic             wc_last, wr_last, ch_last, oc_last, or_last, row_end, mat_end;
  logic [7:0]       col_next, row_next;

  logic [6:0] ypos, xpos, yoff, xoff, tmp1;
  logic [7:0] ch_h;
  logic       in_img;
  logic [12:0] addr_full;

  logic [6:0]           tmp1_r, xoff_r;
  logic                 inside_r, err_r, rend_r, mend_r;
  logic [IDX_W-1:0]     mrow_r, mcol_r;
  logic [ADDR_W-1:0]    addr_r;
  logic [WORD_BITS-1:0] rd_r;

  logic [WORD_BITS-1:0] store_mem [STORE_DEPTH];

  assign cfg_we  = cfg_valid && cmd.idle;
  assign cfg_hit = cfg_we && (cfg_index <= REG_STEP_SIZE);

  always_comb begin
    h_c  = clamp6(height_r, MAX_H6);
    w_c  = clamp6(width_r, MAX_W6);
    kh_c = clamp6(kern_h_r, MAX_K6);
    kw_c = clamp6(kern_w_r, MAX_K6);
    s_c  = clamp6(step_r, MAX_K6);
    ch_c = clamp3(chans_r, MAX_CH3);
    ph   = {1'b0, h_c} + {3'b0, pad_r, 1'b0};
    pw   = {1'b0, w_c} + {3'b0, pad_r, 1'b0};
    geom_err = ({1'b0, kh_c} > ph) || ({1'b0, kw_c} > pw);
  end

  // load position
  always_comb begin
    ldc_last  = ({1'b0, ld_col_r} + 6'd1) == w_c;
    ldr_last  = ({1'b0, ld_row_r} + 6'd1) == h_c;
    ldch_last = ({1'b0, ld_chan_r} + 3'd1) == ch_c;
    ld_pos_nxt  = ld_pos_r;
    ld_col_nxt  = ld_col_r;
    ld_row_nxt  = ld_row_r;
    ld_chan_nxt = ld_chan_r;
    if (cfg_hit) begin
      ld_pos_nxt  = '0;
      ld_col_nxt  = '0;
      ld_row_nxt  = '0;
      ld_chan_nxt = '0;
    end else if (cmd.load_en) begin
      ld_pos_nxt = ld_pos_r + 1'b1;
      ld_col_nxt = ld_col_r + 5'd1;
      if (ldc_last) begin
        ld_col_nxt = '0;
        ld_row_nxt = ld_row_r + 5'd1;
        if (ldr_last) begin
          ld_row_nxt  = '0;
          ld_chan_nxt = ld_chan_r + 2'd1;
          if (ldch_last) begin
            ld_chan_nxt = '0;
            ld_pos_nxt  = '0;
          end
        end
      end
    end
  end

  // window walk
  always_comb begin
    wc_last  = ({1'b0, win_col_r} + 6'd1) == kw_c;
    wr_last  = ({1'b0, win_row_r} + 6'd1) == kh_c;
    ch_last  = ({1'b0, chan_r} + 3'd1) == ch_c;
    col_next = {2'b0, col_base_r} + {2'b0, s_c};
    row_next = {2'b0, row_base_r} + {2'b0, s_c};
    oc_last  = (col_next + {2'b0, kw_c}) > {1'b0, pw};
    or_last  = (row_next + {2'b0, kh_c}) > {1'b0, ph};
    row_end  = wc_last && wr_last && ch_last;
    mat_end  = row_end && oc_last && or_last;

    row_base_nxt = row_base_r;
    col_base_nxt = col_base_r;
    chan_nxt     = chan_r;
    win_row_nxt  = win_row_r;
    win_col_nxt  = win_col_r;
    row_idx_nxt  = row_idx_r;
    col_idx_nxt  = col_idx_r;
    if (cfg_hit) begin
      row_base_nxt = '0;
      col_base_nxt = '0;
      chan_nxt     = '0;
      win_row_nxt  = '0;
      win_col_nxt  = '0;
      row_idx_nxt  = '0;
      col_idx_nxt  = '0;
    end else if (cmd.read_en && !geom_err) begin
      win_col_nxt = win_col_r + 5'd1;
      col_idx_nxt = col_idx_r + 1'b1;
      if (wc_last) begin
        win_col_nxt = '0;
        win_row_nxt = win_row_r + 5'd1;
        if (wr_last) begin
          win_row_nxt = '0;
          chan_nxt    = chan_r + 2'd1;
          if (ch_last) begin
            chan_nxt     = '0;
            col_idx_nxt  = '0;
            row_idx_nxt  = row_idx_r + 1'b1;
            col_base_nxt = col_next[5:0];
            if (oc_last) begin
              col_base_nxt = '0;
              row_base_nxt = row_next[5:0];
              if (or_last) begin
                row_base_nxt = '0;
                row_idx_nxt  = '0;
              end
            end
          end
        end
      end
    end
  end

  // sample coordinate
  always_comb begin
    ypos   = {1'b0, row_base_r} + {2'b0, win_row_r};
    xpos   = {1'b0, col_base_r} + {2'b0, win_col_r};
    yoff   = ypos - {4'b0, pad_r};
    xoff   = xpos - {4'b0, pad_r};
    in_img = (ypos >= {4'b0, pad_r}) && (yoff < {1'b0, h_c}) &&
             (xpos >= {4'b0, pad_r}) && (xoff < {1'b0, w_c});
    ch_h   = {6'b0, chan_r} * {2'b0, h_c};
    tmp1   = ch_h[6:0] + yoff;
    addr_full = (13'(tmp1_r) * 13'(w_c)) + 13'(xoff_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r   <= MAX_H6;
      width_r    <= MAX_W6;
      chans_r    <= 3'd1;
      kern_h_r   <= 6'd3;
      kern_w_r   <= 6'd3;
      pad_r      <= 3'd0;
      step_r     <= 6'd1;
      ld_pos_r   <= '0;
      ld_col_r   <= '0;
      ld_row_r   <= '0;
      ld_chan_r  <= '0;
      row_base_r <= '0;
      col_base_r <= '0;
      chan_r     <= '0;
      win_row_r  <= '0;
      win_col_r  <= '0;
      row_idx_r  <= '0;
      col_idx_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IMAGE_HEIGHT:  height_r <= cfg_data;
          REG_IMAGE_WIDTH:   width_r  <= cfg_data;
          REG_CHANNEL_COUNT: chans_r  <= cfg_data[2:0];
          REG_KERNEL_HEIGHT: kern_h_r <= cfg_data;
          REG_KERNEL_WIDTH:  kern_w_r <= cfg_data;
          REG_PAD_AMOUNT:    pad_r    <= cfg_data[2:0];
          REG_STEP_SIZE:     step_r   <= cfg_data;
          default: begin
          end
        endcase
      end
      ld_pos_r   <= ld_pos_nxt;
      ld_col_r   <= ld_col_nxt;
      ld_row_r   <= ld_row_nxt;
      ld_chan_r  <= ld_chan_nxt;
      row_base_r <= row_base_nxt;
      col_base_r <= col_base_nxt;
      chan_r     <= chan_nxt;
      win_row_r  <= win_row_nxt;
      win_col_r  <= win_col_nxt;
      row_idx_r  <= row_idx_nxt;
      col_idx_r  <= col_idx_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.read_en) begin
      err_r    <= geom_err;
      inside_r <= in_img && !geom_err;
      tmp1_r   <= tmp1;
      xoff_r   <= xoff;
      mrow_r   <= geom_err ? '0 : row_idx_r;
      mcol_r   <= geom_err ? '0 : col_idx_r;
      rend_r   <= row_end && !geom_err;
      mend_r   <= mat_end && !geom_err;
    end
    if (cmd.addr_en) begin
      addr_r <= addr_full[ADDR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_en) begin
      store_mem[ld_pos_r] <= in_pixel_word;
    end
    if (cmd.fetch_en) begin
      rd_r <= store_mem[addr_r];
    end
  end

  assign out_element_word  = inside_r ? rd_r : '0;
  assign out_matrix_row    = mrow_r;
  assign out_matrix_column = mcol_r;
  assign out_row_end       = rend_r;
  assign out_matrix_end    = mend_r;
  assign out_status        = err_r;

endmodule

>>> hw/rtl/im2col_patch_unroller_core.sv
// ----------------------------------------------------------------------------
// im2col_patch_unroller_core
// Sequence: a read word gives its result on out_strobe after passing through
//   address multiply, store read and emit; a load word is stored, no result.
// Throughput: one load per cycle while idle; a new read is accepted only once
//   the previous one has emitted, since the sequencer ignores start while busy.
// Reset: synchronous rst_n clears counters and restores register defaults;
//   the image store holds no reset. The receiver cannot stall out_strobe.
// ----------------------------------------------------------------------------
module im2col_patch_unroller_core import im2col_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_mode,
  input  logic [WORD_BITS-1:0]  in_pixel_word,
  output logic                  out_strobe,
  output logic [WORD_BITS-1:0]  out_element_word,
  output logic [IDX_W-1:0]      out_matrix_row,
  output logic [IDX_W-1:0]      out_matrix_column,
  output logic                  out_row_end,
  output logic                  out_matrix_end,
  output logic                  out_status,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  dp_cmd_t cmd;

  im2col_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_mode    (in_mode),
    .busy       (busy),
    .out_strobe (out_strobe),
    .cmd        (cmd)
  );

  im2col_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .in_pixel_word     (in_pixel_word),
    .cfg_valid         (cfg_valid),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .out_element_word  (out_element_word),
    .out_matrix_row    (out_matrix_row),
    .out_matrix_column (out_matrix_column),
    .out_row_end       (out_row_end),
    .out_matrix_end    (out_matrix_end),
    .out_status        (out_status)
  );

  assign cfg_ready = cmd.idle;

endmodule
